/* sv/image_header_dimension_parser_defines.svh */
// Assertion macros shared by the image header parser checkers.
`ifndef IMAGE_HEADER_DIMENSION_PARSER_DEFINES_SVH
`define IMAGE_HEADER_DIMENSION_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IHDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihdp check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IHDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihdp check failed");

`endif

/* sv/ihdp_pkg.sv */
// Types, constants and helpers for the image header dimension parser.
`default_nettype none
package ihdp_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned HDR_LEN   = 24;  // bytes kept from the file start
  localparam int unsigned WIN_LEN   = 12;  // JPEG segment window
  localparam int unsigned WIN_BASE  = 2;   // window covers header 2..13
  localparam int unsigned JFIF_POS  = 9;   // JFIF test made on this byte
  localparam int unsigned SEG_START = 2;   // first segment position

  localparam byte_t MARKER   = 8'hFF;
  localparam byte_t SOI      = 8'hD8;
  localparam byte_t APP0     = 8'hE0;
  localparam byte_t PNG_SIG0 = 8'h89;
  localparam byte_t PNG_EOF  = 8'h1A;
  localparam byte_t ASC_CR   = 8'h0D;
  localparam byte_t ASC_LF   = 8'h0A;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_JPEG = 2'd1,
    FMT_GIF  = 2'd2,
    FMT_PNG  = 2'd3
  } fmt_t;

  // per-beat control from the input stage to the scan unit
  typedef struct packed {
    logic go;
    logic last_byte;
  } beat_ctl_t;

  function automatic logic is_sof(input byte_t m);
    return (m == 8'hC0) || (m == 8'hC1) || (m == 8'hC2) || (m == 8'hC3) ||
           (m == 8'hC9) || (m == 8'hCA) || (m == 8'hCB);
  endfunction

endpackage
`default_nettype wire

/* sv/ihdp_scan.sv */
// Header capture, JPEG segment walk and position counters.
`default_nettype none
module ihdp_scan import ihdp_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire beat_ctl_t ctl,
  input  wire byte_t     data_byte,
  output byte_t          view [HDR_LEN],
  output logic           long_enough
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  byte_t hdr_r  [HDR_LEN];
  byte_t hdr_nxt[HDR_LEN];
  byte_t win_r  [WIN_LEN];
  byte_t win_nxt[WIN_LEN];
  byte_t tail_r  [WIN_LEN];
  byte_t tail_nxt[WIN_LEN];

  logic [PW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] nsp_r, nsp_nxt;
  logic          scanning_r, scanning_nxt;
  logic          done_r, done_nxt;

  logic          cnt_live;
  logic          jfif_at, jfif_ok, commit;
  logic [3:0]    win_idx;
  logic [PW:0]   end_sum, seg_sum;
  byte_t         seg_w0, seg_w1, seg_w2, seg_w3;
  logic          seg_stop;
  logic [PW-1:0] seg_nsp;

  assign cnt_live = (cnt_r != POS_MAX);
  assign win_idx  = 4'(cnt_r[3:0] - 4'(WIN_BASE));
  assign jfif_at  = cnt_live && (cnt_r == PW'(JFIF_POS));
  assign jfif_ok  = (hdr_r[0] == MARKER) && (hdr_r[1] == SOI) &&
                    (hdr_r[2] == MARKER) && (hdr_r[3] == APP0) &&
                    (hdr_r[6] == 8'h4A) && (hdr_r[7] == 8'h46) &&
                    (hdr_r[8] == 8'h49) && (data_byte == 8'h46);

  // window at nsp ends on byte nsp+11; no commit if that passes saturation
  assign end_sum = {1'b0, nsp_r} + (PW+1)'(WIN_LEN - 1);
  assign commit  = cnt_live && !jfif_at && scanning_r && !done_r &&
                   !end_sum[PW] && (end_sum[PW-1:0] == cnt_r);

  // first step reads the header window, later steps the fresh tail
  assign seg_w0 = jfif_at ? win_r[0] : tail_nxt[0];
  assign seg_w1 = jfif_at ? win_r[1] : tail_nxt[1];
  assign seg_w2 = jfif_at ? win_r[2] : tail_nxt[2];
  assign seg_w3 = jfif_at ? win_r[3] : tail_nxt[3];

  assign seg_stop = (seg_w0 != MARKER) || is_sof(seg_w1);
  assign seg_sum  = {1'b0, nsp_r} + (PW+1)'({seg_w2, seg_w3}) + (PW+1)'(2);
  assign seg_nsp  = seg_sum[PW] ? POS_MAX : seg_sum[PW-1:0];

  always_comb begin
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      tail_nxt[k] = tail_r[k+1];
    end
    tail_nxt[WIN_LEN-1] = data_byte;

    hdr_nxt      = hdr_r;
    win_nxt      = win_r;
    cnt_nxt      = cnt_r;
    nsp_nxt      = nsp_r;
    scanning_nxt = scanning_r;
    done_nxt     = done_r;

    if (cnt_live) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r < PW'(HDR_LEN)) begin
        hdr_nxt[cnt_r[4:0]] = data_byte;
      end
      if ((cnt_r >= PW'(WIN_BASE)) && (cnt_r < PW'(WIN_BASE + WIN_LEN))) begin
        win_nxt[win_idx] = data_byte;
      end
    end

    if (jfif_at) begin
      if (jfif_ok) begin
        scanning_nxt = 1'b1;
        if (seg_stop) done_nxt = 1'b1;
        else          nsp_nxt  = seg_nsp;
      end else begin
        done_nxt = 1'b1;
      end
    end else if (commit) begin
      win_nxt = tail_nxt;
      if (seg_stop) done_nxt = 1'b1;
      else          nsp_nxt  = seg_nsp;
    end
  end

  // header view: window covers positions 2..13
  for (genvar g = 0; g < HDR_LEN; g++) begin : g_view
    if ((g >= WIN_BASE) && (g < WIN_BASE + WIN_LEN)) begin : g_win
      assign view[g] = win_nxt[g - WIN_BASE];
    end else begin : g_hdr
      assign view[g] = hdr_nxt[g];
    end
  end

  assign long_enough = (cnt_nxt >= PW'(HDR_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      nsp_r      <= PW'(SEG_START);
      scanning_r <= 1'b0;
      done_r     <= 1'b0;
    end else if (ctl.go) begin
      if (ctl.last_byte) begin
        cnt_r      <= '0;
        nsp_r      <= PW'(SEG_START);
        scanning_r <= 1'b0;
        done_r     <= 1'b0;
      end else begin
        cnt_r      <= cnt_nxt;
        nsp_r      <= nsp_nxt;
        scanning_r <= scanning_nxt;
        done_r     <= done_nxt;
      end
    end
  end

  // byte stores: every entry is rewritten before a later file reads it
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      hdr_r  <= hdr_nxt;
      win_r  <= win_nxt;
      tail_r <= tail_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/ihdp_decode.sv */
// Format detection and width/height extraction from the header view.
`default_nettype none
module ihdp_decode import ihdp_pkg::*; (
  input  wire byte_t view [HDR_LEN],
  input  wire logic  long_enough,
  output logic        found,
  output fmt_t        image_format,
  output logic [31:0] width,
  output logic [31:0] height
);

  logic is_jpeg, is_gif, is_png;

  assign is_jpeg = (view[0] == MARKER) && (view[1] == SOI) && (view[2] == MARKER);
  assign is_gif  = (view[0] == 8'h47) && (view[1] == 8'h49) && (view[2] == 8'h46);
  assign is_png  = (view[0] == PNG_SIG0) && (view[1] == 8'h50) &&
                   (view[2] == 8'h4E) && (view[3] == 8'h47) &&
                   (view[4] == ASC_CR) && (view[5] == ASC_LF) &&
                   (view[6] == PNG_EOF) && (view[7] == ASC_LF) &&
                   (view[12] == 8'h49) && (view[13] == 8'h48) &&
                   (view[14] == 8'h44) && (view[15] == 8'h52);

  always_comb begin
    image_format = FMT_NONE;
    width        = '0;
    height       = '0;
    priority if (!long_enough) begin
      image_format = FMT_NONE;
    end else if (is_jpeg) begin
      image_format = FMT_JPEG;
      height       = {16'h0, view[7], view[8]};
      width        = {16'h0, view[9], view[10]};
    end else if (is_gif) begin
      image_format = FMT_GIF;
      width        = {16'h0, view[7], view[6]};
      height       = {16'h0, view[9], view[8]};
    end else if (is_png) begin
      image_format = FMT_PNG;
      width        = {view[16], view[17], view[18], view[19]};
      height       = {view[20], view[21], view[22], view[23]};
    end else begin
      image_format = FMT_NONE;
    end
  end

  assign found = (image_format != FMT_NONE);

endmodule
`default_nettype wire

/* sv/image_header_dimension_parser.sv */
// Top level of the image header dimension parser.
// Feed an image file one byte per beat on in_data_byte, flagging the final
// byte with in_last_byte. After that final beat one result beat appears on
// the out_ channel: out_found, out_image_format (0 none, 1 JPEG, 2 GIF,
// 3 PNG), out_width and out_height (both 0 when nothing is recognized).
// GIF and PNG sizes come from fixed offsets in the first 24 bytes. JFIF
// JPEGs are walked segment to segment until a start-of-frame marker or a
// segment not opening with FF; the 12-byte window at each segment start
// only counts once all of it has arrived, so a truncated scan reports the
// last complete window. Other JPEGs report the bytes at offsets 7..10. Files
// under 24 bytes report not found. Throughput is one byte per clock, apart
// from the final-byte stall below: each byte passes through an input
// register, then compare/add logic updates the scan state, and the result
// register is loaded as the final byte leaves the input register. Non-final
// bytes keep flowing while a result waits on out_ready; only a second final
// byte stalls until the pending result is taken. Position counters are
// POSITION_WIDTH bits and saturate. State returns to reset after each file.
`default_nettype none
module image_header_dimension_parser import ihdp_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_found,
  output logic [1:0]       out_image_format,
  output logic [31:0]      out_width,
  output logic [31:0]      out_height
);

  // input stage
  logic        s1_valid_r, s1_valid_nxt;
  byte_t       s1_byte_r;
  logic        s1_last_r;
  logic        in_take;
  logic        s1_go;
  logic        out_free;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r;
  logic [1:0]  out_format_r;
  logic [31:0] out_width_r, out_height_r;

  beat_ctl_t   ctl;
  byte_t       view [HDR_LEN];
  logic        long_enough;
  logic        dec_found;
  fmt_t        dec_format;
  logic [31:0] dec_width, dec_height;

  // a final byte needs room in the result register; others never wait
  assign out_free     = !out_valid_r || out_ready;
  assign s1_go        = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready     = !s1_valid_r || s1_go;
  assign in_take      = in_valid && in_ready;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);

  assign ctl.go        = s1_go;
  assign ctl.last_byte = s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  ihdp_scan #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .data_byte   (s1_byte_r),
    .view        (view),
    .long_enough (long_enough)
  );

  ihdp_decode u_decode (
    .view         (view),
    .long_enough  (long_enough),
    .found        (dec_found),
    .image_format (dec_format),
    .width        (dec_width),
    .height       (dec_height)
  );

  assign out_valid_nxt = (s1_go && s1_last_r) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_found_r  <= dec_found;
      out_format_r <= dec_format;
      out_width_r  <= dec_width;
      out_height_r <= dec_height;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_image_format = out_format_r;
  assign out_width        = out_width_r;
  assign out_height       = out_height_r;

endmodule
`default_nettype wire

/* sv/ihdp_checker.sv */
// Port-level checks for the image header dimension parser, bound to the top.
`default_nettype none
`include "image_header_dimension_parser_defines.svh"
module ihdp_checker import ihdp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_found,
  input wire logic [1:0]  out_image_format,
  input wire logic [31:0] out_width,
  input wire logic [31:0] out_height
);

  logic [66:0] out_beat;
  logic        dims_zero;
  logic        dims_narrow;
  logic        fmt_narrow;

  assign out_beat    = {out_found, out_image_format, out_width, out_height};
  assign dims_zero   = (out_width == 32'h0) && (out_height == 32'h0);
  assign dims_narrow = (out_width[31:16] == 16'h0) && (out_height[31:16] == 16'h0);
  assign fmt_narrow  = (out_image_format == FMT_JPEG) || (out_image_format == FMT_GIF);

  // stalled result beat holds
  `IHDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // found flag agrees with format code
  `IHDP_ASSERT_NOW(a_found_fmt, out_valid, out_found == (out_image_format != FMT_NONE))

  // no dimensions without a recognized format
  `IHDP_ASSERT_NOW(a_zero_dims, out_valid && !out_found, dims_zero)

  // JPEG and GIF carry 16-bit dimensions
  `IHDP_ASSERT_NOW(a_narrow_dims, out_valid && fmt_narrow, dims_narrow)

endmodule

bind image_header_dimension_parser ihdp_checker u_ihdp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found        (out_found),
  .out_image_format (out_image_format),
  .out_width        (out_width),
  .out_height       (out_height)
);
`default_nettype wire
